FILE: hdl/tpb_pkg.sv
// Shared constants, types and codes of the TIM partial bitmap builder.
package tpb_pkg;

  // Station count that the store serves; association IDs at or above it are rejected.
  localparam int MAX_STATIONS = 2048;
  localparam int STORE_WORDS  = 32;
  localparam int WIDX_W       = 5;
  localparam int BIDX_W       = 8;

  // Operation codes of an input item.
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SMALL   = 2'd1;
  localparam logic [1:0] ST_BAD_AID = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_RD,
    S_SET_WR,
    S_RESP,
    S_SCAN,
    S_SCAN_END,
    S_EVAL,
    S_EMIT_PRIME,
    S_EMIT_FILL,
    S_EMIT_OUT
  } tpb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic set_rd;
    logic set_wr;
    logic scan_rd;
    logic emit_start;
    logic emit_fill;
    logic emit_load;
    logic resp_load;
  } tpb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_op;
    logic aid_bad;
    logic scan_last;
    logic too_small;
    logic emit_last;
    logic out_free;
  } tpb_sts_t;

endpackage

FILE: hdl/tpb_if.sv
// Valid/ready channel interfaces for input items and result items.
interface tpb_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [11:0] station_aid;
  logic        buffered;
  logic [8:0]  space_bytes;

  modport source (output valid, output opcode, output station_aid, output buffered,
                  output space_bytes, input ready);
  modport sink (input valid, input opcode, input station_aid, input buffered,
                input space_bytes, output ready);
endinterface

interface tpb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] bitmap_word;
  logic [3:0]  word_bytes;
  logic [6:0]  map_offset;
  logic [8:0]  bitmap_length;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output bitmap_word, output word_bytes,
                  output map_offset, output bitmap_length, output status,
                  output last, input ready);
  modport sink (input valid, input bitmap_word, input word_bytes, input map_offset,
                input bitmap_length, input status, input last, output ready);
endinterface

FILE: hdl/tpb_ctrl.sv
// Controller state machine that sequences set, scan and emit steps.
module tpb_ctrl
  import tpb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tpb_sts_t   sts,
  output tpb_cmd_t   cmd,
  output tpb_state_t state
);

  tpb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (sts.in_op == OP_BUILD) ? S_SCAN : S_SET_RD;
        end
      end
      S_SET_RD:     state_nxt = sts.aid_bad ? S_RESP : S_SET_WR;
      S_SET_WR:     state_nxt = S_RESP;
      S_RESP: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END:   state_nxt = S_EVAL;
      S_EVAL:       state_nxt = sts.too_small ? S_RESP : S_EMIT_PRIME;
      S_EMIT_PRIME: state_nxt = S_EMIT_FILL;
      S_EMIT_FILL:  state_nxt = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (sts.out_free && sts.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_SET_RD:     cmd.set_rd     = !sts.aid_bad;
      S_SET_WR:     cmd.set_wr     = 1'b1;
      S_RESP:       cmd.resp_load  = sts.out_free;
      S_SCAN:       cmd.scan_rd    = 1'b1;
      S_SCAN_END:   cmd            = '0;
      S_EVAL:       cmd            = '0;
      S_EMIT_PRIME: cmd.emit_start = 1'b1;
      S_EMIT_FILL:  cmd.emit_fill  = 1'b1;
      S_EMIT_OUT:   cmd.emit_load  = sts.out_free;
      default:      cmd            = '0;
    endcase
  end

  assign state = state_r;

endmodule

FILE: hdl/tpb_dp.sv
// Datapath: traffic bit store, bitmap bound search, byte packing and result register.
module tpb_dp
  import tpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tpb_cmd_t    cmd,
  output tpb_sts_t    sts,
  input  logic        in_opcode,
  input  logic [11:0] in_station_aid,
  input  logic        in_buffered,
  input  logic [8:0]  in_space_bytes,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [63:0] out_bitmap_word,
  output logic [3:0]  out_word_bytes,
  output logic [6:0]  out_map_offset,
  output logic [8:0]  out_bitmap_length,
  output logic [1:0]  out_status,
  output logic        out_last
);

  // Traffic store with one valid bit per word; an unwritten word reads as zero.
  logic [63:0]            mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] vld_r;
  logic [63:0]            rd_data_r;
  logic                   rd_ok_r;
  logic [63:0]            rd_word;

  // Captured item.
  logic        op_r;
  logic [11:0] aid_r;
  logic        buf_r;
  logic [8:0]  space_r;

  // Scan and emit state.
  logic [WIDX_W-1:0] idx_r;
  logic              scan_v_r;
  logic [WIDX_W-1:0] scan_idx_r;
  logic              found_r;
  logic [BIDX_W-1:0] n1_r, n2_r;
  logic [WIDX_W-1:0] wp_r;
  logic [63:0]       prev_r;
  logic [8:0]        rem_r;

  // Result register.
  logic        out_valid_r;
  logic [63:0] word_r;
  logic [3:0]  bytes_r;
  logic [6:0]  offset_r;
  logic [8:0]  length_r;
  logic [1:0]  status_r;
  logic        last_r;

  logic              aid_bad;
  logic              rd_en;
  logic [WIDX_W-1:0] raddr;
  logic [WIDX_W-1:0] aid_word;
  logic [63:0]       bit_mask;
  logic [63:0]       wdata;
  logic [7:0]        nz_any, nz_first;
  logic [2:0]        first_j, last_j;
  logic [8:0]        len;
  logic              emit_last;
  logic [3:0]        cnt;
  logic [127:0]      dbl;
  logic [127:0]      shifted;
  logic [63:0]       byte_mask;
  logic              out_free;

  assign aid_bad   = aid_r >= 12'(MAX_STATIONS);
  assign aid_word  = aid_r[6 +: WIDX_W];
  assign bit_mask  = 64'd1 << aid_r[5:0];
  assign rd_word   = rd_ok_r ? rd_data_r : '0;
  assign wdata     = buf_r ? (rd_word | bit_mask) : (rd_word & ~bit_mask);
  assign len       = {1'b0, n2_r} - {1'b0, n1_r} + 9'd1;
  assign emit_last = rem_r <= 9'd8;
  assign cnt       = emit_last ? rem_r[3:0] : 4'd8;
  assign out_free  = !out_valid_r || out_ready;

  assign rd_en = cmd.set_rd | cmd.scan_rd | cmd.emit_start | cmd.emit_fill
               | (cmd.emit_load & !emit_last);

  always_comb begin
    if (cmd.set_rd) begin
      raddr = aid_word;
    end else if (cmd.scan_rd) begin
      raddr = idx_r;
    end else if (cmd.emit_start) begin
      raddr = n1_r[BIDX_W-1:3];
    end else begin
      raddr = wp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_wr) begin
      mem[aid_word] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[raddr];
      rd_ok_r   <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.set_wr) begin
      vld_r[aid_word] <= 1'b1;
    end
  end

  // Nonzero bytes of the scanned word; bit 0 of the store does not count toward N1.
  always_comb begin
    first_j = 3'd0;
    last_j  = 3'd0;
    for (int j = 0; j < 8; j++) begin
      nz_any[j]   = |rd_word[8*j +: 8];
      nz_first[j] = nz_any[j];
    end
    if (scan_idx_r == '0) begin
      nz_first[0] = |rd_word[7:1];
    end
    for (int j = 7; j >= 0; j--) begin
      if (nz_first[j]) begin
        first_j = 3'(j);
      end
    end
    for (int j = 0; j < 8; j++) begin
      if (nz_any[j]) begin
        last_j = 3'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      aid_r   <= in_station_aid;
      buf_r   <= in_buffered;
      space_r <= in_space_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_v_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      scan_v_r <= cmd.scan_rd;
      if (cmd.capture) begin
        found_r <= 1'b0;
      end else if (scan_v_r && !found_r && |nz_first) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= idx_r;
    if (cmd.capture) begin
      idx_r <= '0;
      n1_r  <= '0;
      n2_r  <= '0;
    end else begin
      if (cmd.scan_rd) begin
        idx_r <= idx_r + WIDX_W'(1);
      end
      if (scan_v_r && !found_r && |nz_first) begin
        n1_r <= {scan_idx_r, first_j[2:1], 1'b0};
      end
      if (scan_v_r && |nz_any) begin
        n2_r <= {scan_idx_r, last_j};
      end
    end
  end

  // Each result takes up to eight bytes starting at the byte offset of N1 in the current word pair.
  assign dbl     = {rd_word, prev_r};
  assign shifted = dbl >> {n1_r[2:0], 3'b000};

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      byte_mask[8*j +: 8] = (4'(j) < cnt) ? 8'hFF : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      wp_r  <= n1_r[BIDX_W-1:3] + WIDX_W'(1);
      rem_r <= len;
    end else if (cmd.emit_fill) begin
      prev_r <= rd_word;
      wp_r   <= wp_r + WIDX_W'(1);
    end else if (cmd.emit_load) begin
      prev_r <= rd_word;
      rem_r  <= rem_r - 9'd8;
      if (!emit_last) begin
        wp_r <= wp_r + WIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load || cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      word_r   <= shifted[63:0] & byte_mask;
      bytes_r  <= cnt;
      offset_r <= n1_r[BIDX_W-1:1];
      length_r <= len;
      status_r <= ST_OK;
      last_r   <= emit_last;
    end else if (cmd.resp_load) begin
      word_r  <= '0;
      bytes_r <= '0;
      last_r  <= 1'b1;
      if (op_r == OP_BUILD) begin
        offset_r <= n1_r[BIDX_W-1:1];
        length_r <= len;
        status_r <= ST_SMALL;
      end else begin
        offset_r <= '0;
        length_r <= '0;
        status_r <= aid_bad ? ST_BAD_AID : ST_OK;
      end
    end
  end

  assign sts.in_op     = in_opcode;
  assign sts.aid_bad   = aid_bad;
  assign sts.scan_last = idx_r == WIDX_W'(STORE_WORDS - 1);
  assign sts.too_small = space_r < len;
  assign sts.emit_last = emit_last;
  assign sts.out_free  = out_free;

  assign out_valid         = out_valid_r;
  assign out_bitmap_word   = word_r;
  assign out_word_bytes    = bytes_r;
  assign out_map_offset    = offset_r;
  assign out_bitmap_length = length_r;
  assign out_status        = status_r;
  assign out_last          = last_r;

endmodule

FILE: hdl/tim_partial_bitmap_builder_top.sv
// Top level of the TIM partial virtual bitmap builder.
//
// The block keeps one buffered-traffic bit per station association ID in a
// 32-word by 64-bit store. Items arrive on in_ch and results leave on out_ch;
// each channel moves one transfer at a rising edge where valid and ready are
// both high. A set item (opcode 0) writes or clears one station bit and gives
// one result; an ID at or above the station count changes nothing and reports
// an invalid station status.
// A build item (opcode 1) reads all 32 store words through the single read
// port of the store to find N1 and N2, then emits the bitmap bytes N1..N2, up
// to eight per result, one result per cycle when the receiver keeps up. If
// space_bytes is below the bitmap length, one buffer-too-small result comes
// instead.
// One item is worked at a time; in_ch.ready is high only between items. The
// result register lets the next item be taken while the final result still
// waits. When the receiver stalls, the result holds and emission pauses.
// Reset clears the valid bit of every store word at once, so the whole store
// reads as zero from the first cycle after reset, with no clearing pass.
module tim_partial_bitmap_builder_top
  import tpb_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  tpb_in_if.sink    in_ch,
  tpb_out_if.source out_ch
);

  tpb_cmd_t   cmd;
  tpb_sts_t   sts;
  tpb_state_t state;
  logic       in_ready;

  tpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  tpb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_ch.opcode),
    .in_station_aid    (in_ch.station_aid),
    .in_buffered       (in_ch.buffered),
    .in_space_bytes    (in_ch.space_bytes),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_bitmap_word   (out_ch.bitmap_word),
    .out_word_bytes    (out_ch.word_bytes),
    .out_map_offset    (out_ch.map_offset),
    .out_bitmap_length (out_ch.bitmap_length),
    .out_status        (out_ch.status),
    .out_last          (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  // A build transfer starts the store scan in the next cycle.
  a_build_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.opcode == OP_BUILD |=> state == S_SCAN)
    else $error("build transfer did not start the scan");

  // Failure results are always single and carry no bitmap bytes.
  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.last && out_ch.word_bytes == 4'd0)
    else $error("failure result is not a lone empty result");

  // The final result of a build carries the remainder of the bitmap length.
  a_last_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_OK && out_ch.bitmap_length != 9'd0 && out_ch.last
    |-> out_ch.word_bytes == {1'b0, 3'(out_ch.bitmap_length - 9'd1)} + 4'd1)
    else $error("final result byte count disagrees with the bitmap length");

  // No new item is taken while bitmap emission is in progress.
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state == S_EMIT_OUT |-> !in_ch.ready)
    else $error("input taken while bitmap emission is in progress");

endmodule

FILE: tb/sv/tim_partial_bitmap_builder_top_test.sv
// Self-checking testbench for the TIM partial virtual bitmap builder.
module tim_partial_bitmap_builder_top_test;
  import tpb_pkg::*;

  // The store holds one byte per eight association IDs.
  localparam int STORE_BYTES = MAX_STATIONS / 8;
  // A full build with 32 results under heavy receiver stalls stays far below this bound.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Quiet time after the last expected result.
  localparam int DRAIN_CYCLES = 100;
  localparam int SHOWN_ERRORS = 10;

  // One input item as the sender presents it.
  typedef struct packed {
    logic        opcode;
    logic [11:0] station_aid;
    logic        buffered;
    logic [8:0]  space_bytes;
  } tim_req_t;

  // One result item, compared as a whole against the prediction.
  typedef struct packed {
    logic [63:0] bitmap_word;
    logic [3:0]  word_bytes;
    logic [6:0]  map_offset;
    logic [8:0]  bitmap_length;
    logic [1:0]  status;
    logic        last;
  } tim_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tpb_in_if  in_ch();
  tpb_out_if out_ch();

  tim_partial_bitmap_builder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the traffic store, updated at every accepted set item with a valid station ID.
  logic [63:0] traffic_model [STORE_WORDS];
  // Results that the accepted items must still produce, oldest first.
  tim_result_t expected_results[$];

  // Idling knobs for the current phase, in percent of cycles.
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  // A nonzero value makes the receiver hold off for that many cycles.
  int rx_hold_cycles = 0;

  int fail_count     = 0;
  int cycle_count    = 0;
  int items_sent     = 0;
  int set_items      = 0;
  int bad_aid_items  = 0;
  int builds_ok      = 0;
  int builds_small   = 0;
  int results_seen   = 0;
  int longest_bitmap = 0;

  function automatic logic [7:0] store_byte(int idx);
    return traffic_model[idx / 8][(idx % 8) * 8 +: 8];
  endfunction

  // N1 is the even byte at or below the first byte with a set bit above
  // bit 0; N2 is the last nonzero byte, never below N1.
  function automatic void bitmap_span(output int n1, output int n2);
    logic [7:0] b;
    bit         seen;
    n1   = 0;
    n2   = 0;
    seen = 1'b0;
    for (int i = 0; i < STORE_BYTES; i++) begin
      b = store_byte(i);
      if (i == 0)
        b[0] = 1'b0;
      if (!seen && b != 8'd0) begin
        n1   = i & ~1;
        seen = 1'b1;
      end
      if (store_byte(i) != 8'd0)
        n2 = i;
    end
    if (n2 < n1)
      n2 = n1;
  endfunction

  function automatic int bitmap_length_now();
    int n1;
    int n2;
    bitmap_span(n1, n2);
    return n2 - n1 + 1;
  endfunction

  // Applies one accepted item to the store copy and queues the results it causes.
  function automatic void predict_item(tim_req_t it);
    tim_result_t r;
    int          n1;
    int          n2;
    int          len;
    int          cnt;
    r = '0;
    if (it.opcode == OP_SET) begin
      r.last = 1'b1;
      set_items++;
      if (it.station_aid >= MAX_STATIONS) begin
        r.status = ST_BAD_AID;
        bad_aid_items++;
      end else begin
        traffic_model[it.station_aid / 64][it.station_aid % 64] = it.buffered;
        r.status = ST_OK;
      end
      expected_results.push_back(r);
      return;
    end
    bitmap_span(n1, n2);
    len = n2 - n1 + 1;
    r.map_offset    = 7'(n1 / 2);
    r.bitmap_length = 9'(len);
    if (it.space_bytes < len) begin
      r.status = ST_SMALL;
      r.last   = 1'b1;
      builds_small++;
      expected_results.push_back(r);
      return;
    end
    builds_ok++;
    if (len > longest_bitmap)
      longest_bitmap = len;
    r.status = ST_OK;
    for (int i = 0; i < len; i += 8) begin
      cnt = (len - i < 8) ? len - i : 8;
      r.bitmap_word = '0;
      for (int j = 0; j < cnt; j++)
        r.bitmap_word[j * 8 +: 8] = store_byte(n1 + i + j);
      r.word_bytes = 4'(cnt);
      r.last       = (i + cnt >= len);
      expected_results.push_back(r);
    end
  endfunction

  function automatic tim_req_t set_req(int aid, bit buffered);
    tim_req_t it;
    it.opcode      = OP_SET;
    it.station_aid = 12'(aid);
    it.buffered    = buffered;
    it.space_bytes = 9'($urandom_range(256));
    return it;
  endfunction

  // The AID and buffered fields are ignored by a build, so they carry noise.
  function automatic tim_req_t build_req(int space);
    tim_req_t it;
    it.opcode      = OP_BUILD;
    it.station_aid = 12'($urandom);
    it.buffered    = 1'($urandom);
    it.space_bytes = 9'(space);
    return it;
  endfunction

  // Mostly enough space for the current bitmap, with a share of builds
  // that fall just short, far short or land anywhere.
  function automatic int pick_space(int len);
    int pick;
    pick = $urandom_range(99);
    if (pick < 60)
      return $urandom_range(256, len);
    else if (pick < 75)
      return len - 1;
    else if (pick < 85)
      return $urandom_range(len - 1, 0);
    return $urandom_range(256);
  endfunction

  // Offers one item, with random idle cycles in front of it, and waits for
  // its transfer. Valid is left high so the next item can follow at once.
  task automatic send_item(tim_req_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= it.opcode;
    in_ch.station_aid <= it.station_aid;
    in_ch.buffered    <= it.buffered;
    in_ch.space_bytes <= it.space_bytes;
    do
      @(posedge clk);
    while (!in_ch.ready);
    predict_item(it);
    items_sent++;
  endtask

  // Clears every bit that is set in the AID range, one set item each.
  task automatic clear_stations(int lo, int hi);
    for (int aid = lo; aid <= hi; aid++)
      if (traffic_model[aid / 64][aid % 64])
        send_item(set_req(aid, 1'b0));
  endtask

  // Reset leaves the store empty: N1 = N2 = 0 and a one-byte bitmap of
  // zero, too large for a zero-byte space.
  task automatic test_empty_store();
    send_item(build_req(0));
    send_item(build_req(1));
    send_item(build_req(256));
  endtask

  // AID 0 sits in bit 0, which the N1 search skips. IDs at or above the
  // station count must leave the store untouched.
  task automatic test_station_ids();
    send_item(set_req(0, 1'b1));
    send_item(build_req(8));
    send_item(set_req(MAX_STATIONS, 1'b1));
    send_item(set_req(4095, 1'b0));
    send_item(set_req(0, 1'b0));
    send_item(build_req(1));
  endtask

  // N1 at the top of the store, N1 rounded down from an odd byte, and a
  // full 256-byte bitmap with one byte too little and exactly enough space.
  task automatic test_span_edges();
    send_item(set_req(MAX_STATIONS - 1, 1'b1));
    send_item(build_req(256));
    send_item(set_req(9, 1'b1));
    send_item(build_req(255));
    send_item(build_req(256));
    send_item(set_req(9, 1'b0));
    send_item(set_req(15, 1'b1));
    send_item(set_req(MAX_STATIONS - 1, 1'b0));
    send_item(build_req(2));
    send_item(set_req(15, 1'b0));
  endtask

  // The receiver holds off while full-length builds keep coming, so the
  // result path backs up and the input channel has to stall.
  task automatic test_receiver_holdoff();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_item(set_req(1, 1'b1));
    send_item(set_req(MAX_STATIONS - 1, 1'b1));
    rx_hold_cycles = 400;
    repeat (3)
      send_item(build_req(256));
    send_item(set_req(1, 1'b0));
    send_item(set_req(MAX_STATIONS - 1, 1'b0));
  endtask

  // Random traffic grouped into AID windows, so that N1, N2 and the bitmap
  // length move around the whole store. Windows are often cleared again
  // afterwards, which keeps the bitmaps from simply growing to full size.
  task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items);
    int       start_count;
    int       span;
    int       lo;
    int       burst;
    int       set_pct;
    int       pick;
    tim_req_t it;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    start_count  = items_sent;
    clear_stations(0, MAX_STATIONS - 1);
    while (items_sent - start_count < n_items) begin
      span = ($urandom_range(3) == 0) ? $urandom_range(255, 32) : $urandom_range(31);
      case ($urandom_range(3))
        0: lo = 0;
        1: lo = MAX_STATIONS - 1 - span;
        default: lo = $urandom_range(MAX_STATIONS - 1 - span);
      endcase
      set_pct = ($urandom_range(1) == 0) ? 80 : 40;
      burst   = $urandom_range(16, 4);
      repeat (burst) begin
        pick = $urandom_range(99);
        if (pick < 8)
          it = set_req($urandom_range(4095, MAX_STATIONS), 1'($urandom));
        else if (pick < 52)
          it = set_req($urandom_range(lo + span, lo), $urandom_range(99) < set_pct);
        else
          it = build_req(pick_space(bitmap_length_now()));
        send_item(it);
      end
      if ($urandom_range(99) < 70)
        clear_stations(lo, lo + span);
    end
  endtask

  // The receiver stalls at random, or for a whole hold-off when one is asked for.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic void report_failure(string what, tim_result_t exp_r, tim_result_t got);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS) begin
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      $display("  expected word=%h bytes=%0d offset=%0d length=%0d status=%0d last=%0d",
               exp_r.bitmap_word, exp_r.word_bytes, exp_r.map_offset,
               exp_r.bitmap_length, exp_r.status, exp_r.last);
      $display("  actual   word=%h bytes=%0d offset=%0d length=%0d status=%0d last=%0d",
               got.bitmap_word, got.word_bytes, got.map_offset,
               got.bitmap_length, got.status, got.last);
    end
  endfunction

  // Every result transfer is matched against the oldest expected result.
  always @(posedge clk) begin
    tim_result_t got;
    tim_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.bitmap_word   = out_ch.bitmap_word;
      got.word_bytes    = out_ch.word_bytes;
      got.map_offset    = out_ch.map_offset;
      got.bitmap_length = out_ch.bitmap_length;
      got.status        = out_ch.status;
      got.last          = out_ch.last;
      results_seen++;
      if (expected_results.size() == 0)
        report_failure("result transfer with no result expected", '0, got);
      else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r)
          report_failure("result differs from prediction", exp_r, got);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_SET;
    in_ch.station_aid = '0;
    in_ch.buffered    = 1'b0;
    in_ch.space_bytes = '0;
    for (int w = 0; w < STORE_WORDS; w++)
      traffic_model[w] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_station_ids();
    test_span_edges();
    test_random_traffic(0, 0, 100);
    test_receiver_holdoff();
    test_random_traffic(54, 0, 100);
    test_random_traffic(0, 54, 100);
    test_random_traffic(25, 25, 100);

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d set items (%0d with invalid station ID), %0d builds",
             items_sent, set_items, bad_aid_items, builds_ok + builds_small);
    $display("Builds: %0d complete, %0d too small, longest bitmap %0d bytes; %0d results",
             builds_ok, builds_small, longest_bitmap, results_seen);
    if (fail_count == 0)
      $display("All tests passed");
    else begin
      $display("%0d mismatches in total", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
